>>> hw/rtl/tlbpt_pkg.sv
// Shared constants, types and helpers for the TLB page-table translator.
package tlbpt_pkg;

  localparam int ADDR_W         = 16;
  localparam int OFFSET_W       = 8;
  localparam int FRAME_W        = 8;
  localparam int PAGE_SPACE     = 256;  // pages addressable by an 8-bit page field
  localparam int FREE_W         = 9;
  localparam int FRAME_LIMIT    = 256;
  localparam int COUNT_W        = 16;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 56;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;

  // out_tdata field positions
  localparam int OUT_PHYS_LSB   = 0;
  localparam int OUT_HIT_BIT    = 16;
  localparam int OUT_FAULT_BIT  = 17;
  localparam int OUT_HTOT_LSB   = 18;
  localparam int OUT_FTOT_LSB   = 34;
  localparam int OUT_USED_W     = 50;

  typedef struct packed {
    logic accept;  // capture request, start TLB compare and table read
    logic commit;  // resolve request, update tables, load result register
  } cmd_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

>>> hw/rtl/tlb_page_table_translator.sv
// Top level of the TLB page-table address translator.
// Translates one 16-bit logical address per request (page in [15:8], offset in
// [7:0]) through a fully associative TLB backed by a page table, allocating
// frames in order on a page fault and refilling the TLB round-robin on every
// miss. Each request has an accept cycle, which runs the parallel TLB
// compare and launches the page-table read, and a resolve cycle, which uses the
// registered read data, updates the tables and loads the result register.
// in_tready is high only between requests; a result held in the output
// register does not block the next accept, but the resolve cycle waits while
// the output register is still full. Pages are reduced modulo PAGE_COUNT
// before use. Hit and fault totals saturate at 0xFFFF. No clearing pass is
// needed after reset.
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,  // 2..64
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF    // 16..256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] logical_addr
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] physical_addr, [16] tlb_hit, [17] page_fault,
  // [33:18] hit_total, [49:34] fault_total, [55:50] zero
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  tlbpt_pkg::cmd_t cmd;

  // sequencer: accept -> resolve, with result-register handshake
  tlbpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // TLB, page table, allocator and counters
  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

>>> hw/rtl/tlbpt_ctrl.sv
// Controller: two-state sequencer and result-register valid flag.
module tlbpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output tlbpt_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        // hold until the result register is free or draining
        cmd.commit = !out_valid_r || out_tready;
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> hw/rtl/tlbpt_datapath.sv
// Datapath: TLB cells, page table memory, frame allocator, counters, result register.
module tlbpt_datapath #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlbpt_pkg::cmd_t                    cmd,
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int SLOT_W = $clog2(TLB_ENTRIES);
  localparam int FW     = tlbpt_pkg::FRAME_W;
  localparam int OW     = tlbpt_pkg::OFFSET_W;
  localparam int CW     = tlbpt_pkg::COUNT_W;
  localparam int FREE_W = tlbpt_pkg::FREE_W;

  // page number reduced modulo the table size, as a constant lookup
  logic [PAGE_W-1:0] page_map [tlbpt_pkg::PAGE_SPACE];
  for (genvar g = 0; g < tlbpt_pkg::PAGE_SPACE; g++) begin : g_map
    assign page_map[g] = PAGE_W'(g % PAGE_COUNT);
  end

  logic [PAGE_W-1:0] page_in;
  assign page_in = page_map[in_tdata[tlbpt_pkg::ADDR_W-1:OW]];

  // TLB cells
  logic [PAGE_W-1:0]      tlb_tag_r   [TLB_ENTRIES];
  logic [FW-1:0]          tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [SLOT_W-1:0]      slot_r;

  logic [TLB_ENTRIES-1:0] hit_vec;
  logic [FW-1:0]          hit_frame;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_vec[i] = tlb_valid_r[i] && (tlb_tag_r[i] == page_in);
      if (hit_vec[i]) begin
        hit_frame = hit_frame | tlb_frame_r[i];
      end
    end
  end

  // page table: frame memory with registered read, valid bits in flops
  logic [FW-1:0]         table_mem [PAGE_COUNT];
  logic [FW-1:0]         table_rd_r;
  logic [PAGE_COUNT-1:0] table_valid_r;

  // request captured at accept
  logic [PAGE_W-1:0] page_r;
  logic [OW-1:0]     offset_r;
  logic              hit_r;
  logic [FW-1:0]     hit_frame_r;

  logic [FREE_W-1:0] free_r;
  logic [CW-1:0]     hit_cnt_r;
  logic [CW-1:0]     fault_cnt_r;

  logic              fault;
  logic [FW-1:0]     frame;
  logic [CW-1:0]     hit_cnt_nxt;
  logic [CW-1:0]     fault_cnt_nxt;

  always_comb begin
    fault         = !hit_r && !table_valid_r[page_r];
    if (hit_r) begin
      frame = hit_frame_r;
    end else if (!fault) begin
      frame = table_rd_r;
    end else begin
      frame = free_r[FW-1:0];
    end
    hit_cnt_nxt   = hit_r ? tlbpt_pkg::sat_inc(hit_cnt_r) : hit_cnt_r;
    fault_cnt_nxt = fault ? tlbpt_pkg::sat_inc(fault_cnt_r) : fault_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r      <= page_in;
      offset_r    <= in_tdata[OW-1:0];
      hit_r       <= |hit_vec;
      hit_frame_r <= hit_frame;
      table_rd_r  <= table_mem[page_in];
    end
    if (cmd.commit && fault) begin
      table_mem[page_r] <= free_r[FW-1:0];
    end
    if (cmd.commit && !hit_r) begin
      tlb_tag_r[slot_r]   <= page_r;
      tlb_frame_r[slot_r] <= frame;
    end
    if (cmd.commit) begin
      out_tdata <= {(tlbpt_pkg::OUT_TDATA_W - tlbpt_pkg::OUT_USED_W)'(0),
                    fault_cnt_nxt, hit_cnt_nxt, fault, hit_r, frame, offset_r};
    end
  end

  // control-type state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r   <= '0;
      slot_r        <= '0;
      table_valid_r <= '0;
      free_r        <= '0;
      hit_cnt_r     <= '0;
      fault_cnt_r   <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r   <= hit_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      if (fault) begin
        table_valid_r[page_r] <= 1'b1;
        if (free_r < FREE_W'(tlbpt_pkg::FRAME_LIMIT)) begin
          free_r <= free_r + FREE_W'(1);
        end
      end
      if (!hit_r) begin
        tlb_valid_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tlbpt_checker.sv
// Port-level checker for the TLB page-table translator, bound to the top level.
module tlbpt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [tlbpt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tlbpt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a request is never both a TLB hit and a page fault
  a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[tlbpt_pkg::OUT_HIT_BIT] &&
                     out_tdata[tlbpt_pkg::OUT_FAULT_BIT]))
    else $error("hit and fault both set");

  // one request at a time: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back accept");

  // each page faults at most once, so the fault total stays within the page space
  a_fault_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tlbpt_pkg::OUT_FTOT_LSB +: tlbpt_pkg::COUNT_W]
                   <= tlbpt_pkg::COUNT_W'(tlbpt_pkg::PAGE_SPACE))
    else $error("fault total exceeds page count");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

>>> tb/tlb_xlat_checker.sv
// Checker for the TLB translator: predicts each translation and compares results.
`timescale 1ns / 1ps

module tlb_xlat_checker
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     pending_count
);

  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic               hit;
    logic               fault;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } xlat_t;

  // predictor state
  logic [7:0]         tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_q [TLB_ENTRIES];
  logic               tlb_live    [TLB_ENTRIES];
  int                 tlb_fill_ptr;
  logic [FRAME_W-1:0] page_frame  [PAGE_COUNT];
  logic               page_mapped [PAGE_COUNT];
  logic [FREE_W-1:0]  next_free_frame;
  logic [COUNT_W-1:0] hit_tally;
  logic [COUNT_W-1:0] fault_tally;

  xlat_t pending_xlat[$];

  function automatic xlat_t translate_addr(input logic [ADDR_W-1:0] laddr);
    xlat_t r;
    int page;
    logic [FRAME_W-1:0] frame;
    r     = '0;
    page  = int'(laddr[15:8]) % PAGE_COUNT;
    frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!r.hit && tlb_live[i] && tlb_page_q[i] == page[7:0]) begin
        r.hit = 1'b1;
        frame = tlb_frame_q[i];
      end
    end
    if (r.hit) begin
      if (hit_tally != '1) hit_tally = hit_tally + 1'b1;
    end else begin
      if (page_mapped[page]) begin
        frame = page_frame[page];
      end else begin
        r.fault = 1'b1;
        if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
        frame = next_free_frame[FRAME_W-1:0];
        if (next_free_frame < FRAME_LIMIT) next_free_frame = next_free_frame + 1'b1;
        page_frame[page]  = frame;
        page_mapped[page] = 1'b1;
      end
      // FIFO refill of the TLB on every miss
      tlb_page_q[tlb_fill_ptr]  = page[7:0];
      tlb_frame_q[tlb_fill_ptr] = frame;
      tlb_live[tlb_fill_ptr]    = 1'b1;
      tlb_fill_ptr = (tlb_fill_ptr + 1) % TLB_ENTRIES;
    end
    r.phys   = {frame, laddr[7:0]};
    r.hits   = hit_tally;
    r.faults = fault_tally;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    xlat_t want;
    if (!rst_n) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_page_q[i]  = '0;
        tlb_frame_q[i] = '0;
        tlb_live[i]    = 1'b0;
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
        page_frame[p]  = '0;
        page_mapped[p] = 1'b0;
      end
      tlb_fill_ptr    = 0;
      next_free_frame = '0;
      hit_tally       = '0;
      fault_tally     = '0;
      pending_xlat.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_xlat.size() == 0) begin
          report_mismatch("result with no request pending", out_tdata[31:0], 32'h0);
        end else begin
          want = pending_xlat.pop_front();
          check_field("physical_addr", out_tdata[OUT_PHYS_LSB +: ADDR_W], want.phys);
          check_field("tlb_hit", out_tdata[OUT_HIT_BIT], want.hit);
          check_field("page_fault", out_tdata[OUT_FAULT_BIT], want.fault);
          check_field("hit_total", out_tdata[OUT_HTOT_LSB +: COUNT_W], want.hits);
          check_field("fault_total", out_tdata[OUT_FTOT_LSB +: COUNT_W], want.faults);
          check_field("pad bits", out_tdata[OUT_TDATA_W-1:OUT_USED_W], 32'h0);
        end
      end
      if (in_tvalid && in_tready) pending_xlat.push_back(translate_addr(in_tdata));
    end
    pending_count = pending_xlat.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the TLB translator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import tlbpt_pkg::*;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int RAND_REQS   = 1800;
  // watchdog limit: keep a wide margin over the slowest correct run
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] logical_addr
  logic                   out_tvalid;
  logic                   out_tready;
  // [15:0] physical_addr, [16] tlb_hit, [17] page_fault,
  // [33:18] hit_total, [49:34] fault_total, [55:50] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  int          mismatches;
  int          pending;
  int unsigned cycle_count;

  // when set, that side runs without idle cycles
  bit src_steady;
  bit snk_steady;

  // page history used to steer requests toward TLB hits and table hits
  logic [7:0] recent_pages[$];
  logic [7:0] seen_pages[$];
  bit         page_seen[256];

  tlb_page_table_translator #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  tlb_xlat_checker #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatches),
    .pending_count (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink: random stall before each result, then hold tready until taken
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = snk_steady ? 0 : $urandom_range(0, 10);
      while (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        gap--;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Issue one request. tvalid stays high after the handshake so that a
  // zero gap gives back-to-back requests without a low pulse.
  task automatic send_request(input logic [15:0] laddr);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 10);
    while (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      gap--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= laddr;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic note_page(input logic [7:0] page);
    if (!page_seen[page]) begin
      page_seen[page] = 1'b1;
      seen_pages.push_back(page);
    end
    recent_pages.push_back(page);
    if (recent_pages.size() > 8) void'(recent_pages.pop_front());
  endtask

  initial begin
    logic [7:0] page;
    int         pick;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, hit right after fault, TLB wrap, then a
    // page evicted from the TLB that must come back from the table
    send_request(16'h0000);  // first fault, frame 0
    send_request(16'h00FF);  // TLB hit, max offset
    send_request(16'hFFFF);  // top page faults
    send_request(16'hFF00);  // hit
    send_request(16'hAA55);
    send_request(16'h55AA);
    for (int p = 16'h10; p <= 16'h1F; p++) send_request({p[7:0], p[7:0] ^ 8'h5A});
    send_request(16'h0012);  // page 0 evicted: miss without fault
    send_request(16'h1F80);  // still resident: hit
    note_page(8'h00); note_page(8'hFF); note_page(8'hAA); note_page(8'h55);
    for (int p = 16'h10; p <= 16'h1F; p++) note_page(p[7:0]);

    // random: recent pages most often (TLB hits), earlier pages (table hits),
    // the rest uniform (faults and evictions); idling changes every 100 requests
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 0) begin
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      else if (pick < 75) page = seen_pages[$urandom_range(0, seen_pages.size() - 1)];
      else page = 8'($urandom_range(0, 255));
      note_page(page);
      send_request({page, 8'($urandom_range(0, 255))});
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    snk_steady = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_ctrl.sv
hw/rtl/tlbpt_datapath.sv
hw/rtl/tlb_page_table_translator.sv
hw/rtl/tlbpt_checker.sv
tb/tlb_xlat_checker.sv
tb/tb.sv
